### design/ssvfb_pkg.sv
// Package for the seven-segment value frame builder: widths, bus command
// bytes, the segment lookup and the sequencer state type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ssvfb_pkg;

  localparam int unsigned MAG_W       = 17;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned BCD_DIGITS  = 5;
  localparam int unsigned BCD_W       = 4 * BCD_DIGITS;
  localparam int unsigned DIGIT_COUNT = 6;
  localparam int unsigned BYTE_COUNT  = DIGIT_COUNT + 3;
  localparam int unsigned BCNT_W      = $clog2(BYTE_COUNT);
  localparam int unsigned POS_W       = 3;
  localparam int unsigned STEP_W      = $clog2(MAG_W + 1);

  localparam logic [MAG_W-1:0] MAG_MAX = MAG_W'(99999);

  localparam logic [BYTE_W-1:0] CMD_DATA_WRITE = 8'h40;
  localparam logic [BYTE_W-1:0] CMD_ADDRESS    = 8'hC3;
  localparam logic [BYTE_W-1:0] CMD_CONTROL    = 8'h80;
  localparam logic [BYTE_W-1:0] SEG_DOT        = 8'h80;
  localparam logic [BYTE_W-1:0] SEG_MINUS      = 8'h40;
  localparam logic [BYTE_W-1:0] SEG_BLANK      = 8'h00;

  // positions of the bytes within one value's sequence
  localparam logic [BCNT_W-1:0] BYTE_DATA_CMD = BCNT_W'(0);
  localparam logic [BCNT_W-1:0] BYTE_ADDR_CMD = BCNT_W'(1);
  localparam logic [BCNT_W-1:0] BYTE_SEG0     = BCNT_W'(2);
  localparam logic [BCNT_W-1:0] BYTE_SEG_LAST = BCNT_W'(DIGIT_COUNT + 1);
  localparam logic [BCNT_W-1:0] BYTE_CTRL     = BCNT_W'(BYTE_COUNT - 1);

  localparam logic [POS_W-1:0] DOT_POS = POS_W'(2);
  localparam logic [POS_W-1:0] SHOWN_3 = POS_W'(3);
  localparam logic [POS_W-1:0] SHOWN_4 = POS_W'(4);
  localparam logic [POS_W-1:0] SHOWN_5 = POS_W'(5);

  // configuration register indexes
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_ENABLE = 1'b1;
  localparam logic [2:0] BRIGHTNESS_RESET = 3'd6;
  localparam logic       ENABLE_RESET     = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SEND
  } state_e;

  function automatic logic [BYTE_W-1:0] seg_lut(input logic [3:0] digit);
    logic [BYTE_W-1:0] seg;
    case (digit)
      4'd0:    seg = 8'h3F;
      4'd1:    seg = 8'h06;
      4'd2:    seg = 8'h5B;
      4'd3:    seg = 8'h4F;
      4'd4:    seg = 8'h66;
      4'd5:    seg = 8'h6D;
      4'd6:    seg = 8'h7D;
      4'd7:    seg = 8'h07;
      4'd8:    seg = 8'h7F;
      4'd9:    seg = 8'h6F;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

`default_nettype wire

### design/ssvfb_if.sv
// Channel interfaces for the frame builder: value in, bus beats out.
// Depends on ssvfb_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ssvfb_in_if
  import ssvfb_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [MAG_W-1:0] magnitude;
  logic             is_negative;

  modport source (output valid, output magnitude, output is_negative, input ready);
  modport sink   (input valid, input magnitude, input is_negative, output ready);
endinterface

interface ssvfb_out_if
  import ssvfb_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] bus_byte;
  logic              frame_start;
  logic              frame_end;
  logic              last_byte;

  modport source (output valid, output bus_byte, output frame_start, output frame_end,
                  output last_byte, input ready);
  modport sink   (input valid, input bus_byte, input frame_start, input frame_end,
                  input last_byte, output ready);
endinterface

`default_nettype wire

### design/ssvfb_bcd.sv
// Bit-serial binary to bcd converter (shift and add-three), one input bit
// per cycle. Depends on ssvfb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssvfb_bcd
  import ssvfb_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [MAG_W-1:0] value_i,
  output logic                  done_o,
  output logic [BCD_W-1:0]      bcd_o
);

  logic [MAG_W-1:0]  bin_q, bin_d;
  logic [BCD_W-1:0]  bcd_q, bcd_d;
  logic [BCD_W-1:0]  adj;
  logic [STEP_W-1:0] step_q, step_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;

  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      bin_d  = value_i;
      bcd_d  = '0;
      step_d = STEP_W'(MAG_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      bcd_d  = {adj[BCD_W-2:0], bin_q[MAG_W-1]};
      bin_d  = {bin_q[MAG_W-2:0], 1'b0};
      step_d = step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= STEP_W'(MAG_W))
    else $error("step counter out of range");

  a_done_after_last_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !start_i && step_q == STEP_W'(1) |=> done_q && !busy_q)
    else $error("conversion did not finish on last step");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("done held for more than one cycle");

endmodule

`default_nettype wire

### design/seven_segment_value_frame_builder.sv
// Top level of the seven-segment value frame builder: takes a value, converts
// it to bcd and sends nine bus beats. Depends on ssvfb_pkg, ssvfb_if, ssvfb_bcd.
//
//   channel    dir  handshake        payload
//   value_i    in   valid / ready    magnitude[16:0], is_negative
//   frame_o    out  valid / ready    bus_byte[7:0], frame_start, frame_end, last_byte
//   cfg_*_i    in   cfg_we_i         cfg_index_i (0 brightness, 1 display_enable)
//
// one value is accepted, converted one bit per cycle in the shift and add-three
// converter, has its digits handed over and is then sent as nine output beats;
// no new value is taken in until the control beat of the last one is loaded.
// reset sets brightness 6 and display enable 1 and empties the output register.
// a stalled sink holds the current beat; the last beat may wait while the
// next value is already taken in.
`timescale 1ns / 1ps
`default_nettype none

module seven_segment_value_frame_builder
  import ssvfb_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  ssvfb_in_if.sink                   value_i,
  ssvfb_out_if.source                frame_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  state_e state_q, state_d;

  logic [2:0]        brightness_q;
  logic              display_enable_q;
  logic [BCNT_W-1:0] byte_cnt_q, byte_cnt_d;
  logic [BCD_W-1:0]  digits_q, digits_d;
  logic [POS_W-1:0]  shown_q, shown_d;
  logic              neg_q, neg_d;

  logic              out_valid_q;
  logic [BYTE_W-1:0] out_byte_q;
  logic              out_start_q, out_end_q, out_last_q;

  logic              in_fire;
  logic              load;
  logic              conv_start;
  logic              conv_done;
  logic [BCD_W-1:0]  conv_bcd;
  logic [MAG_W-1:0]  sat_mag;
  logic [POS_W-1:0]  seg_pos;
  logic [BYTE_W-1:0] seg_byte;
  logic [BYTE_W-1:0] next_byte;
  logic              next_start, next_end, next_last;

  assign in_fire = value_i.valid && value_i.ready;
  assign sat_mag = (value_i.magnitude > MAG_MAX) ? MAG_MAX : value_i.magnitude;

  ssvfb_bcd u_bcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (conv_start),
    .value_i (sat_mag),
    .done_o  (conv_done),
    .bcd_o   (conv_bcd)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (value_i.valid) state_d = ST_CONV;
      ST_CONV: if (conv_done)     state_d = ST_SEND;
      ST_SEND: if (load && byte_cnt_q == BYTE_CTRL) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    value_i.ready = 1'b0;
    conv_start    = 1'b0;
    load          = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        value_i.ready = 1'b1;
        conv_start    = value_i.valid;
      end
      ST_CONV: ;
      ST_SEND: load = !out_valid_q || frame_o.ready;
      default: ;
    endcase
  end

  // segment byte for the digit at the low nibble of the shift register
  always_comb begin
    seg_pos = POS_W'(byte_cnt_q - BYTE_SEG0);
    if (seg_pos < shown_q) begin
      seg_byte = seg_lut(digits_q[3:0]) | ((seg_pos == DOT_POS) ? SEG_DOT : SEG_BLANK);
    end else if (neg_q && seg_pos == shown_q) begin
      seg_byte = SEG_MINUS;
    end else begin
      seg_byte = SEG_BLANK;
    end
  end

  always_comb begin
    next_start = 1'b0;
    next_end   = 1'b0;
    next_last  = 1'b0;
    case (byte_cnt_q)
      BYTE_DATA_CMD: begin
        next_byte  = CMD_DATA_WRITE;
        next_start = 1'b1;
        next_end   = 1'b1;
      end
      BYTE_ADDR_CMD: begin
        next_byte  = CMD_ADDRESS;
        next_start = 1'b1;
      end
      BYTE_CTRL: begin
        next_byte  = CMD_CONTROL | {4'b0000, display_enable_q, brightness_q};
        next_start = 1'b1;
        next_end   = 1'b1;
        next_last  = 1'b1;
      end
      default: begin
        next_byte = seg_byte;
        next_end  = (byte_cnt_q == BYTE_SEG_LAST);
      end
    endcase
  end

  always_comb begin
    byte_cnt_d = byte_cnt_q;
    digits_d   = digits_q;
    shown_d    = shown_q;
    neg_d      = neg_q;
    if (in_fire) begin
      neg_d = value_i.is_negative;
    end
    if (conv_done) begin
      digits_d   = conv_bcd;
      byte_cnt_d = BYTE_DATA_CMD;
      if (conv_bcd[19:16] != 4'd0) begin
        shown_d = SHOWN_5;
      end else if (conv_bcd[15:12] != 4'd0) begin
        shown_d = SHOWN_4;
      end else begin
        shown_d = SHOWN_3;
      end
    end else if (load) begin
      byte_cnt_d = byte_cnt_q + BCNT_W'(1);
      // move the next digit down once its segment beat is out
      if (byte_cnt_q >= BYTE_SEG0 && byte_cnt_q <= BYTE_SEG_LAST) begin
        digits_d = {4'd0, digits_q[BCD_W-1:4]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      byte_cnt_q       <= '0;
      out_valid_q      <= 1'b0;
      brightness_q     <= BRIGHTNESS_RESET;
      display_enable_q <= ENABLE_RESET;
    end else begin
      state_q    <= state_d;
      byte_cnt_q <= byte_cnt_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (frame_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_BRIGHTNESS:     brightness_q     <= cfg_wdata_i[2:0];
          REG_DISPLAY_ENABLE: display_enable_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    digits_q <= digits_d;
    shown_q  <= shown_d;
    neg_q    <= neg_d;
    if (load) begin
      out_byte_q  <= next_byte;
      out_start_q <= next_start;
      out_end_q   <= next_end;
      out_last_q  <= next_last;
    end
  end

  assign frame_o.valid       = out_valid_q;
  assign frame_o.bus_byte    = out_byte_q;
  assign frame_o.frame_start = out_start_q;
  assign frame_o.frame_end   = out_end_q;
  assign frame_o.last_byte   = out_last_q;

  a_accept_starts_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == ST_CONV)
    else $error("accepted value did not start conversion");

  a_done_in_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    conv_done |-> state_q == ST_CONV)
    else $error("conversion finished outside conversion state");

  a_byte_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SEND |-> byte_cnt_q <= BYTE_CTRL)
    else $error("byte counter past control byte");

  a_last_is_framed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_last_q |-> out_start_q && out_end_q)
    else $error("last beat not framed on its own");

endmodule

`default_nettype wire
